// ===== rtl/core/wbwc_pkg.sv =====
// Shared types and constants for the base-w digit encoder with checksum.
package wbwc_pkg;

	localparam int WORD_BITS  = 64;
	localparam int ACC_W      = 11;
	localparam int IDX_W      = 8;
	localparam int CNT_W      = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 4;

	localparam logic [2:0] MAX_WORDS = 3'd4;
	localparam logic [3:0] MAX_CSUM  = 4'd8;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_MSG_WORDS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DIGIT_MODE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CSUM_DIGITS = 2'd2;

	// Reset values of the configuration registers.
	localparam logic [2:0] RST_MSG_WORDS   = 3'd4;
	localparam logic       RST_DIGIT_MODE  = 1'b1;
	localparam logic [3:0] RST_CSUM_DIGITS = 4'd3;

	// Digit mode codes.
	localparam logic MODE_W4  = 1'b0;
	localparam logic MODE_W16 = 1'b1;

	// One classified word, handed from the front end to the back end.
	typedef struct packed {
		logic [WORD_BITS-1:0] word;
		logic                 mode;
		logic [IDX_W-1:0]     base_idx;
		logic                 ends;
		logic [3:0]           cd;
		logic [IDX_W-1:0]     csum_idx0;
	} desc_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_MSG,
		BK_CSUM
	} back_state_t;

endpackage

// ===== rtl/core/wots_base_w_checksum_encoder.sv =====
// Top level of the base-w digit encoder with Winternitz checksum.
//
// The block takes a message hash as 64-bit words, first word first, and
// splits each word into base-w digits, most significant first: 16 four-bit
// digits when digit_mode is 1 (w = 16) or 32 two-bit digits when it is 0
// (w = 4). Every digit leaves as one output transfer together with its
// position in the full digit vector. Along the way the block sums (w-1-digit)
// over the message digits into an 11-bit checksum; after the last word of a
// message (msg_words words, clamped to 1..4) it appends csum_digits checksum
// digits (clamped to 8) least significant first, at descending positions that
// start from the end of the vector. The sum is split as it is, without the
// left shift that some schemes apply. The last flag marks the final digit that
// a word produces. A front end counts words and classifies each one as it is
// accepted, and pushes it into a two-entry queue; a back end walks the queued
// word one digit per cycle, while out_stall is low, into a registered output.
// A word yields 16 digits at w = 16 or 32 at w = 4, plus csum_digits checksum
// digits on a message's last word. While the back end works, the queue takes
// the next words; output stall holds up the back end, and in_stall rises only
// once the queue is full. Configuration registers are written through the
// plain write port and should be changed only while the block is idle; the
// block itself does not latch the word count of a message in progress.
module wots_base_w_checksum_encoder #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Configuration write port.
	input  logic                              cfg_wr_en,
	input  logic [wbwc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [wbwc_pkg::CFG_DATA_W-1:0]   cfg_data,
	// Input words.
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [wbwc_pkg::WORD_BITS-1:0]    msg_word,
	// Output digits.
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [wbwc_pkg::IDX_W-1:0]        digit_index,
	output logic [3:0]                        digit,
	output logic                              is_checksum,
	output logic                              last
);

	logic            push;
	logic            pop;
	logic            q_full;
	logic            q_empty;
	wbwc_pkg::desc_t push_desc;
	wbwc_pkg::desc_t head;

	// Accepts words, holds the configuration and tracks the word count.
	wbwc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.msg_word  (msg_word),
		.q_full    (q_full),
		.push      (push),
		.push_desc (push_desc)
	);

	// Decouples word acceptance from digit output.
	wbwc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.pop       (pop),
		.head      (head),
		.full      (q_full),
		.empty     (q_empty)
	);

	// Emits message and checksum digits one per cycle while out_stall is low.
	wbwc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.q_empty     (q_empty),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.digit_index (digit_index),
		.digit       (digit),
		.is_checksum (is_checksum),
		.last        (last)
	);

endmodule

// ===== rtl/core/wbwc_front.sv =====
// Front end: configuration registers, word counting and word classification.
module wbwc_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [wbwc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [wbwc_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [wbwc_pkg::WORD_BITS-1:0]     msg_word,
	input  logic                               q_full,
	output logic                               push,
	output wbwc_pkg::desc_t                    push_desc
);

	logic [2:0] msg_words_q;
	logic       digit_mode_q;
	logic [3:0] csum_digits_q;
	logic [2:0] word_count_q;

	logic [2:0] mw_c;
	logic [3:0] cd_c;
	logic [2:0] wc_next;
	logic       ends_c;
	logic [7:0] len1_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msg_words_q   <= wbwc_pkg::RST_MSG_WORDS;
			digit_mode_q  <= wbwc_pkg::RST_DIGIT_MODE;
			csum_digits_q <= wbwc_pkg::RST_CSUM_DIGITS;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				wbwc_pkg::REG_MSG_WORDS:   msg_words_q   <= cfg_data[2:0];
				wbwc_pkg::REG_DIGIT_MODE:  digit_mode_q  <= cfg_data[0];
				wbwc_pkg::REG_CSUM_DIGITS: csum_digits_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// Out-of-range settings are clamped to the nearest legal value.
	always_comb begin
		if (msg_words_q == 3'd0)
			mw_c = 3'd1;
		else if (msg_words_q > wbwc_pkg::MAX_WORDS)
			mw_c = wbwc_pkg::MAX_WORDS;
		else
			mw_c = msg_words_q;
		cd_c    = (csum_digits_q > wbwc_pkg::MAX_CSUM) ? wbwc_pkg::MAX_CSUM : csum_digits_q;
		wc_next = word_count_q + 3'd1;
		ends_c  = (wc_next >= mw_c);
		len1_c  = (digit_mode_q == wbwc_pkg::MODE_W16) ? {1'b0, mw_c, 4'b0000}
		                                               : {mw_c, 5'b00000};
	end

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	always_comb begin
		push_desc.word      = msg_word;
		push_desc.mode      = digit_mode_q;
		push_desc.base_idx  = (digit_mode_q == wbwc_pkg::MODE_W16)
		                      ? {1'b0, word_count_q, 4'b0000} : {word_count_q, 5'b00000};
		push_desc.ends      = ends_c;
		push_desc.cd        = cd_c;
		push_desc.csum_idx0 = len1_c + {4'b0000, cd_c} - 8'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_count_q <= 3'd0;
		end else if (push) begin
			word_count_q <= ends_c ? 3'd0 : wc_next;
		end
	end

endmodule

// ===== rtl/core/wbwc_queue.sv =====
// Short queue of classified words between the front end and the back end.
module wbwc_queue #(
	parameter int DEPTH = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  wbwc_pkg::desc_t push_desc,
	input  logic            pop,
	output wbwc_pkg::desc_t head,
	output logic            full,
	output logic            empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	wbwc_pkg::desc_t  entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_desc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/core/wbwc_back.sv =====
// Back end: digit extraction, checksum accumulation and the output register.
module wbwc_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  wbwc_pkg::desc_t             head,
	input  logic                        q_empty,
	output logic                        pop,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [wbwc_pkg::IDX_W-1:0]  digit_index,
	output logic [3:0]                  digit,
	output logic                        is_checksum,
	output logic                        last
);

	wbwc_pkg::back_state_t state_q, state_d;

	logic [wbwc_pkg::WORD_BITS-1:0] word_sh_q;
	logic                           mode_q;
	logic [wbwc_pkg::IDX_W-1:0]     idx_q;
	logic [wbwc_pkg::IDX_W-1:0]     csum_idx0_q;
	logic                           ends_q;
	logic [3:0]                     cd_q;
	logic [wbwc_pkg::CNT_W-1:0]     cnt_q;
	logic [wbwc_pkg::ACC_W-1:0]     acc_q;

	logic                           out_valid_q;
	logic [wbwc_pkg::IDX_W-1:0]     digit_index_q;
	logic [3:0]                     digit_q;
	logic                           is_checksum_q;
	logic                           last_q;

	logic       adv;
	logic       emit;
	logic       load;
	logic [3:0] cur_dig;
	logic [3:0] csum_dig;
	logic [3:0] wmax;
	logic       msg_last;
	logic       csum_last;
	logic       has_csum;
	logic [3:0] emit_dig;
	logic       emit_last;

	assign adv      = !out_valid_q || !out_stall;
	assign cur_dig  = (mode_q == wbwc_pkg::MODE_W16) ? word_sh_q[63:60]
	                                                 : {2'b00, word_sh_q[63:62]};
	assign csum_dig = (mode_q == wbwc_pkg::MODE_W16) ? acc_q[3:0] : {2'b00, acc_q[1:0]};
	assign wmax     = (mode_q == wbwc_pkg::MODE_W16) ? 4'd15 : 4'd3;
	assign msg_last = (mode_q == wbwc_pkg::MODE_W16) ? (cnt_q == 5'd15) : (cnt_q == 5'd31);
	assign csum_last = (cnt_q == {1'b0, cd_q - 4'd1});
	assign has_csum = ends_q && (cd_q != 4'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= wbwc_pkg::BK_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		emit      = 1'b0;
		load      = 1'b0;
		emit_dig  = cur_dig;
		emit_last = 1'b0;
		case (state_q)
			wbwc_pkg::BK_IDLE: begin
				if (!q_empty) begin
					load    = 1'b1;
					state_d = wbwc_pkg::BK_MSG;
				end
			end
			wbwc_pkg::BK_MSG: begin
				emit_last = msg_last && !has_csum;
				if (adv) begin
					emit = 1'b1;
					if (msg_last) begin
						if (has_csum) begin
							state_d = wbwc_pkg::BK_CSUM;
						end else if (!q_empty) begin
							load = 1'b1;
						end else begin
							state_d = wbwc_pkg::BK_IDLE;
						end
					end
				end
			end
			wbwc_pkg::BK_CSUM: begin
				emit_dig  = csum_dig;
				emit_last = csum_last;
				if (adv) begin
					emit = 1'b1;
					if (csum_last) begin
						if (!q_empty) begin
							load    = 1'b1;
							state_d = wbwc_pkg::BK_MSG;
						end else begin
							state_d = wbwc_pkg::BK_IDLE;
						end
					end
				end
			end
			default: state_d = wbwc_pkg::BK_IDLE;
		endcase
	end

	assign pop = load;

	always_ff @(posedge clk) begin
		if (load) begin
			word_sh_q   <= head.word;
			mode_q      <= head.mode;
			idx_q       <= head.base_idx;
			csum_idx0_q <= head.csum_idx0;
			ends_q      <= head.ends;
			cd_q        <= head.cd;
			cnt_q       <= '0;
		end else if (emit && state_q == wbwc_pkg::BK_MSG) begin
			word_sh_q <= (mode_q == wbwc_pkg::MODE_W16) ? {word_sh_q[59:0], 4'b0000}
			                                            : {word_sh_q[61:0], 2'b00};
			if (msg_last) begin
				idx_q <= csum_idx0_q;
				cnt_q <= '0;
			end else begin
				idx_q <= idx_q + 8'd1;
				cnt_q <= cnt_q + 5'd1;
			end
		end else if (emit) begin
			idx_q <= idx_q - 8'd1;
			cnt_q <= cnt_q + 5'd1;
		end
	end

	// The checksum register is consumed in place by the checksum digits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (emit && state_q == wbwc_pkg::BK_MSG) begin
			if (msg_last && ends_q && cd_q == 4'd0)
				acc_q <= '0;
			else
				acc_q <= acc_q + {7'b0, wmax - cur_dig};
		end else if (emit) begin
			if (csum_last)
				acc_q <= '0;
			else
				acc_q <= (mode_q == wbwc_pkg::MODE_W16) ? {4'b0000, acc_q[10:4]}
				                                        : {2'b00, acc_q[10:2]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv)
			out_valid_q <= emit;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			digit_index_q <= idx_q;
			digit_q       <= emit_dig;
			is_checksum_q <= (state_q == wbwc_pkg::BK_CSUM);
			last_q        <= emit_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign digit_index = digit_index_q;
	assign digit       = digit_q;
	assign is_checksum = is_checksum_q;
	assign last        = last_q;

endmodule

// ===== rtl/core/wbwc_checker.sv =====
// Port-level checks for the digit encoder, bound to the top level.
module wbwc_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic [wbwc_pkg::IDX_W-1:0] digit_index,
	input logic [3:0]                 digit,
	input logic                       is_checksum,
	input logic                       last
);

	// A stalled digit stays offered and unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(digit_index) && $stable(digit)
		&& $stable(is_checksum) && $stable(last))
		else $error("stalled output changed");

	// No position lies beyond the longest digit vector.
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> digit_index <= 8'd135)
		else $error("digit index out of range");

	// Checksum digits sit behind at least one word of message digits.
	a_csum_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_checksum |-> digit_index >= 8'd16)
		else $error("checksum digit placed inside the message part");

	// Nothing is offered in the first cycle after reset.
	a_reset_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !out_valid)
		else $error("output valid right after reset");

endmodule

bind wots_base_w_checksum_encoder wbwc_checker u_wbwc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.digit_index (digit_index),
	.digit       (digit),
	.is_checksum (is_checksum),
	.last        (last)
);
